// File: rtl/bspr_pkg.sv
// Shared types and constants for the ball sprite position and render block.
package bspr_pkg;

    // Command codes carried by each input item.
    typedef enum logic [3:0] {
        CMD_PIXEL_TICK  = 4'd0,
        CMD_MOVE_TICK   = 4'd1,
        CMD_RESET_POS   = 4'd2,
        CMD_ENABLE      = 4'd3,
        CMD_SHUFFLE     = 4'd4,
        CMD_SIZE        = 4'd5,
        CMD_VDELAY      = 4'd6,
        CMD_NEXT_LINE   = 4'd7,
        CMD_MOTION_CLKS = 4'd8,
        CMD_START_MOVE  = 4'd9
    } t_cmd;

    // Position decode that restarts the render counter.
    localparam int POS_RENDER_START = 156;
    // Bias applied to a written position to get the render counter.
    localparam int POS_RESET_BIAS   = 157;

    // Phase codes of the starfield quirk.
    localparam logic [1:0] PHASE_ZERO_WIDTH = 2'd2;
    localparam logic [1:0] PHASE_WIDE       = 2'd3;

    // Ball width from the two size bits: 1, 2, 4 or 8 pixels.
    function automatic logic [3:0] size_width(input logic [1:0] sel);
        logic [3:0] w;
        case (sel)
            2'd0:    w = 4'd1;
            2'd1:    w = 4'd2;
            2'd2:    w = 4'd4;
            default: w = 4'd8;
        endcase
        return w;
    endfunction

endpackage

// File: rtl/bspr_if.sv
// Valid/ready channel interfaces for command items and result items.
interface bspr_in_if;
    logic               valid;
    logic               ready;
    bspr_pkg::t_cmd     cmd;
    logic [7:0]         value;
    logic [3:0]         move_clock;
    logic               hblank;
    logic               regular_clock;

    modport source (output valid, cmd, value, move_clock, hblank, regular_clock,
                    input ready);
    modport sink   (input valid, cmd, value, move_clock, hblank, regular_clock,
                    output ready);
endinterface

interface bspr_out_if;
    logic valid;
    logic ready;
    logic ball_visible;
    logic update_strobe;

    modport source (output valid, ball_visible, update_strobe, input ready);
    modport sink   (input valid, ball_visible, update_strobe, output ready);
endinterface

// File: rtl/ball_sprite_position_render.sv
// Ball sprite position counter, render counter and enable logic, top level.
//
// The block takes one command item per clock cycle unless the output stalls, and returns
// one result item for each in the next cycle. All state updates for an item happen in
// the cycle it is accepted; the result (visibility and update strobe) sits in an output
// register until the downstream side takes it. The input is ready whenever that register
// is empty or is being drained in the same cycle, so a steady stream moves at one item per
// cycle and a stall on the output side stops the input for exactly as long as it lasts.
// The horizontal position wraps at LINE_PIXELS; when it decodes position 156 the render
// counter restarts at minus RENDER_DELAY, and the ball signal is active while that counter
// is non-negative and below the ball width. Movement ticks clock the position only in
// horizontal blank while motion is running, and a regular clock during motion applies the
// starfield width quirk. No clearing pass is needed after reset.
module ball_sprite_position_render #(
    parameter int LINE_PIXELS  = 160,
    parameter int RENDER_DELAY = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    bspr_in_if.sink        i_item,
    bspr_out_if.source     o_result
);
    import bspr_pkg::*;

    // Sprite state.
    logic [7:0]        r_pos,      n_pos;
    logic signed [8:0] r_rcount,   n_rcount;
    logic              r_rendering, n_rendering;
    logic              r_sig,      n_sig;
    logic              r_vis,      n_vis;
    logic              r_en_new,   n_en_new;
    logic              r_en_old,   n_en_old;
    logic              r_delay,    n_delay;
    logic              r_en_now,   n_en_now;
    logic [3:0]        r_width,    n_width;
    logic [3:0]        r_eff_width, n_eff_width;
    logic              r_moving,   n_moving;
    logic [3:0]        r_mclks,    n_mclks;
    logic [7:0]        r_last_pos, n_last_pos;

    // Result register.
    logic              r_out_valid;
    logic              r_out_vis;
    logic              r_out_strobe;
    logic              n_strobe;

    logic              accept;
    logic              do_tick;
    logic              star;
    logic [1:0]        phase;
    logic [8:0]        pos_inc;
    logic [3:0]        limit;
    logic signed [8:0] render_start;

    assign i_item.ready = !r_out_valid || o_result.ready;
    assign accept       = i_item.valid && i_item.ready;

    assign render_start = -$signed(9'(RENDER_DELAY));

    always_comb begin
        n_pos       = r_pos;
        n_rcount    = r_rcount;
        n_rendering = r_rendering;
        n_sig       = r_sig;
        n_vis       = r_vis;
        n_en_new    = r_en_new;
        n_en_old    = r_en_old;
        n_delay     = r_delay;
        n_en_now    = r_en_now;
        n_width     = r_width;
        n_eff_width = r_eff_width;
        n_moving    = r_moving;
        n_mclks     = r_mclks;
        n_last_pos  = r_last_pos;
        n_strobe    = 1'b0;
        do_tick     = 1'b0;

        // Decode the command; pixel work shared by two commands follows below.
        unique case (i_item.cmd)
            CMD_PIXEL_TICK: begin
                do_tick = 1'b1;
            end
            CMD_MOVE_TICK: begin
                n_last_pos = r_pos;
                n_moving   = r_moving && (i_item.move_clock != r_mclks);
                do_tick    = n_moving && i_item.hblank;
            end
            CMD_RESET_POS: begin
                n_pos       = i_item.value;
                n_rendering = 1'b1;
                n_rcount    = $signed({1'b0, i_item.value}) - 9'sd157
                              - $signed(9'(RENDER_DELAY));
            end
            CMD_ENABLE: begin
                n_en_new = i_item.value[0];
                if (i_item.value[0] != r_en_new && !r_delay) begin
                    n_en_now = i_item.value[0];
                    n_vis    = r_sig && i_item.value[0];
                    n_strobe = 1'b1;
                end
            end
            CMD_SHUFFLE: begin
                n_en_old = r_en_new;
                if (r_en_old != r_en_new && r_delay) begin
                    n_en_now = r_en_new;
                    n_vis    = r_sig && r_en_new;
                    n_strobe = 1'b1;
                end
            end
            CMD_SIZE: begin
                n_width = size_width(i_item.value[5:4]);
            end
            CMD_VDELAY: begin
                if (i_item.value[0] != r_delay) begin
                    n_delay  = i_item.value[0];
                    n_en_now = i_item.value[0] ? r_en_old : r_en_new;
                    n_vis    = r_sig && n_en_now;
                    n_strobe = 1'b1;
                end
            end
            CMD_NEXT_LINE: begin
                n_sig = r_rendering && !r_rcount[8];
                n_vis = n_sig && r_en_now;
            end
            CMD_MOTION_CLKS: begin
                n_mclks = i_item.value[3:0];
            end
            CMD_START_MOVE: begin
                n_moving = 1'b1;
            end
            default: begin
            end
        endcase

        // Pixel clock: sample the signal, then advance the counters.
        star    = n_moving && i_item.regular_clock;
        phase   = 2'(POS_RENDER_START + LINE_PIXELS) - n_last_pos[1:0];
        pos_inc = {1'b0, r_pos} + 9'd1;
        limit   = star ? r_eff_width : r_width;
        if (do_tick) begin
            n_sig = r_rendering && !r_rcount[8];
            n_vis = n_sig && r_en_now;
            if (r_pos == 8'(POS_RENDER_START)) begin
                n_rendering = 1'b1;
                n_rcount    = render_start;
                if (star && phase == PHASE_WIDE && r_width < 4'd4) begin
                    n_rcount = render_start + 9'sd1;
                end
                if (phase == PHASE_WIDE) begin
                    n_eff_width = (r_width == 4'd1) ? 4'd2 : r_width;
                end else if (phase == PHASE_ZERO_WIDTH) begin
                    n_eff_width = 4'd0;
                end else begin
                    n_eff_width = r_width;
                end
            end else if (r_rendering) begin
                n_rcount = r_rcount + 9'sd1;
                if (n_rcount >= $signed({5'd0, limit})) begin
                    n_rendering = 1'b0;
                end
            end
            // Wrap the position at the line length.
            n_pos = (pos_inc >= 9'(LINE_PIXELS)) ? 8'd0 : pos_inc[7:0];
        end
    end

    // Commit state on every accepted item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= 8'd0;
            r_rcount    <= 9'sd0;
            r_rendering <= 1'b0;
            r_sig       <= 1'b0;
            r_vis       <= 1'b0;
            r_en_new    <= 1'b0;
            r_en_old    <= 1'b0;
            r_delay     <= 1'b0;
            r_en_now    <= 1'b0;
            r_width     <= 4'd1;
            r_eff_width <= 4'd1;
            r_moving    <= 1'b0;
            r_mclks     <= 4'd0;
            r_last_pos  <= 8'd0;
        end else if (accept) begin
            r_pos       <= n_pos;
            r_rcount    <= n_rcount;
            r_rendering <= n_rendering;
            r_sig       <= n_sig;
            r_vis       <= n_vis;
            r_en_new    <= n_en_new;
            r_en_old    <= n_en_old;
            r_delay     <= n_delay;
            r_en_now    <= n_en_now;
            r_width     <= n_width;
            r_eff_width <= n_eff_width;
            r_moving    <= n_moving;
            r_mclks     <= n_mclks;
            r_last_pos  <= n_last_pos;
        end
    end

    // Result register: load on accept, drop when taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_vis    <= n_vis;
            r_out_strobe <= n_strobe;
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.ball_visible  = r_out_vis;
    assign o_result.update_strobe = r_out_strobe;

endmodule

// File: rtl/bspr_checker.sv
// Port-level checker for the ball sprite block and its bind statement.
module bspr_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           i_in_ready,
    input bspr_pkg::t_cmd i_in_cmd,
    input logic           i_out_valid,
    input logic           i_out_ready,
    input logic           i_out_visible,
    input logic           i_out_strobe
);
    import bspr_pkg::*;

    logic in_acc;
    assign in_acc = i_in_valid && i_in_ready;

    // Every accepted item shows its result in the next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> i_out_valid)
        else $error("accepted item has no result next cycle");

    // Only enable, shuffle and vdelay writes can raise the strobe.
    a_strobe_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_cmd != CMD_ENABLE && i_in_cmd != CMD_SHUFFLE
         && i_in_cmd != CMD_VDELAY) |=> !i_out_strobe)
        else $error("strobe raised by a command that cannot re-evaluate enable");

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // Hold a stalled result.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
        (i_out_valid && $stable(i_out_visible) && $stable(i_out_strobe)))
        else $error("stalled result changed");

endmodule

bind ball_sprite_position_render bspr_checker u_bspr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_item.valid),
    .i_in_ready    (i_item.ready),
    .i_in_cmd      (i_item.cmd),
    .i_out_valid   (o_result.valid),
    .i_out_ready   (o_result.ready),
    .i_out_visible (o_result.ball_visible),
    .i_out_strobe  (o_result.update_strobe)
);
